// ===== hdl/i2cesr_pkg.sv =====
`default_nettype none
package i2cesr_pkg;

	localparam int unsigned TICKS_PER_PHASE_DEF = 1;

	// register indexes on the config port
	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_WORD_ADDRESS   = 2'd1;
	localparam logic [1:0] CFG_READ_LENGTH    = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h50;
	localparam logic [7:0] WORD_ADDRESS_RST   = 8'h00;
	localparam logic [7:0] READ_LENGTH_RST    = 8'd150;

	// which byte of the addressing sequence is on the wire
	localparam logic [1:0] STG_DEV_WR = 2'd0;
	localparam logic [1:0] STG_WORD   = 2'd1;
	localparam logic [1:0] STG_DEV_RD = 2'd2;

	typedef enum logic [14:0] {
		PH_IDLE      = 15'h0001,
		PH_ST_HIGH   = 15'h0002,
		PH_ST_FALL   = 15'h0004,
		PH_WR_LOW    = 15'h0008,
		PH_WR_HIGH   = 15'h0010,
		PH_WACK_LOW  = 15'h0020,
		PH_WACK_HIGH = 15'h0040,
		PH_RD_LOW    = 15'h0080,
		PH_RD_HIGH   = 15'h0100,
		PH_MACK_LOW  = 15'h0200,
		PH_MACK_HIGH = 15'h0400,
		PH_SP_LOW    = 15'h0800,
		PH_SP_HIGH   = 15'h1000,
		PH_SP_END    = 15'h2000,
		PH_RS_LOW    = 15'h4000
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] page;
		logic       sda_in;
	} tick_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       last_byte;
		logic       busy_res;
		logic       done_res;
		logic       nack_seen;
	} bus_result_t;

	function automatic logic [7:0] write_byte(input logic [1:0] stg, input logic [6:0] dev,
			input logic [7:0] word);
		logic [7:0] b;
		case (stg)
			STG_DEV_WR: b = {dev, 1'b0};
			STG_WORD:   b = word;
			default:    b = {dev, 1'b1};
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/i2cesr_stream_if.sv =====
`default_nettype none
interface i2cesr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/i2cesr_core.sv =====
`default_nettype none
module i2cesr_core import i2cesr_pkg::*; #(
	parameter int unsigned TICKS_PER_PHASE = TICKS_PER_PHASE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  step,
	input  wire tick_item_t            item,
	output bus_result_t                res
);
	localparam int unsigned TW = $clog2(TICKS_PER_PHASE + 1);

	logic [6:0] dev_addr_q;
	logic [7:0] word_addr_q;
	logic [7:0] rd_len_q;

	phase_t        phase_q, phase_d;
	logic [TW-1:0] tick_q, tick_d;
	logic [2:0]    bit_q, bit_d;
	logic [1:0]    stage_q, stage_d;
	logic [7:0]    sh_q, sh_d;
	logic [8:0]    rem_q, rem_d;
	logic          pzero_q, pzero_d;
	logic          nack_q, nack_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= DEVICE_ADDRESS_RST;
			word_addr_q <= WORD_ADDRESS_RST;
			rd_len_q    <= READ_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data[6:0];
				CFG_WORD_ADDRESS:   word_addr_q <= cfg_data;
				CFG_READ_LENGTH:    rd_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic          busy;
		logic          is_end;
		logic          is_last;
		logic [TW-1:0] tick_inc;

		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		stage_d = stage_q;
		sh_d    = sh_q;
		rem_d   = rem_q;
		pzero_d = pzero_q;
		nack_d  = nack_q;
		res     = '0;
		res.scl = 1'b1;

		if (item.action && phase_q == PH_IDLE) begin
			pzero_d = (item.page == 8'd0);
			nack_d  = 1'b0;
			stage_d = STG_DEV_WR;
			tick_d  = '0;
			phase_d = PH_ST_HIGH;
		end

		busy     = (phase_d != PH_IDLE);
		tick_inc = tick_d + TW'(1);
		is_end   = (tick_inc >= TW'(TICKS_PER_PHASE));
		is_last  = (rem_d == 9'd1);
		if (busy)
			tick_d = is_end ? '0 : tick_inc;

		case (phase_d)
			PH_IDLE: ;
			PH_ST_HIGH: begin
				res.sda_drive = 1'b1; res.sda_out = 1'b1;
				if (is_end) phase_d = PH_ST_FALL;
			end
			PH_ST_FALL: begin
				res.sda_drive = 1'b1;
				if (is_end) begin
					sh_d    = write_byte(stage_d, dev_addr_q, word_addr_q);
					bit_d   = '0;
					phase_d = PH_WR_LOW;
				end
			end
			PH_WR_LOW: begin
				res.scl = 1'b0; res.sda_drive = 1'b1; res.sda_out = sh_d[7];
				if (is_end) phase_d = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				res.sda_drive = 1'b1; res.sda_out = sh_d[7];
				if (is_end) begin
					sh_d = {sh_d[6:0], 1'b0};
					if (bit_d != 3'd7) begin
						bit_d   = bit_d + 3'd1;
						phase_d = PH_WR_LOW;
					end else begin
						phase_d = PH_WACK_LOW;
					end
				end
			end
			PH_WACK_LOW: begin
				res.scl = 1'b0;
				if (is_end) phase_d = PH_WACK_HIGH;
			end
			PH_WACK_HIGH: begin
				if (is_end) begin
					if (item.sda_in) nack_d = 1'b1;
					if (stage_d == STG_DEV_WR && pzero_d) begin
						stage_d = STG_WORD;
						sh_d    = write_byte(STG_WORD, dev_addr_q, word_addr_q);
						bit_d   = '0;
						phase_d = PH_WR_LOW;
					end else if (stage_d != STG_DEV_RD) begin
						stage_d = STG_DEV_RD;
						phase_d = PH_RS_LOW;
					end else begin
						// zero length wraps to 256 bytes
						rem_d   = (rd_len_q == 8'd0) ? 9'd256 : {1'b0, rd_len_q};
						bit_d   = '0;
						sh_d    = '0;
						phase_d = PH_RD_LOW;
					end
				end
			end
			PH_RS_LOW: begin
				res.scl = 1'b0; res.sda_drive = 1'b1; res.sda_out = 1'b1;
				if (is_end) phase_d = PH_ST_HIGH;
			end
			PH_RD_LOW: begin
				res.scl = 1'b0;
				if (is_end) phase_d = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				if (is_end) begin
					sh_d = {sh_d[6:0], item.sda_in};
					if (bit_d != 3'd7) begin
						bit_d   = bit_d + 3'd1;
						phase_d = PH_RD_LOW;
					end else begin
						res.byte_valid = 1'b1;
						res.read_byte  = sh_d;
						res.last_byte  = is_last;
						phase_d        = PH_MACK_LOW;
					end
				end
			end
			PH_MACK_LOW: begin
				res.scl = 1'b0; res.sda_drive = 1'b1; res.sda_out = is_last;
				if (is_end) phase_d = PH_MACK_HIGH;
			end
			PH_MACK_HIGH: begin
				res.sda_drive = 1'b1; res.sda_out = is_last;
				if (is_end) begin
					if (is_last || rem_d == 9'd0) begin
						phase_d = PH_SP_LOW;
					end else begin
						rem_d   = rem_d - 9'd1;
						bit_d   = '0;
						sh_d    = '0;
						phase_d = PH_RD_LOW;
					end
				end
			end
			PH_SP_LOW: begin
				res.scl = 1'b0; res.sda_drive = 1'b1;
				if (is_end) phase_d = PH_SP_HIGH;
			end
			PH_SP_HIGH: begin
				res.sda_drive = 1'b1;
				if (is_end) phase_d = PH_SP_END;
			end
			PH_SP_END: begin
				res.sda_drive = 1'b1; res.sda_out = 1'b1;
				if (is_end) begin
					res.done_res = 1'b1;
					phase_d      = PH_IDLE;
				end
			end
			default: begin
				// corrupt phase code: behave as idle
				busy    = 1'b0;
				tick_d  = tick_q;
				phase_d = PH_IDLE;
			end
		endcase

		res.busy_res  = busy;
		res.nack_seen = nack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			stage_q <= STG_DEV_WR;
			sh_q    <= '0;
			rem_q   <= '0;
			pzero_q <= 1'b0;
			nack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			stage_q <= stage_d;
			sh_q    <= sh_d;
			rem_q   <= rem_d;
			pzero_q <= pzero_d;
			nack_q  <= nack_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/i2cesr_out_reg.sv =====
`default_nettype none
module i2cesr_out_reg import i2cesr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire bus_result_t res,
	output logic             can_load,
	i2cesr_stream_if.source  out_ch
);
	logic        valid_q;
	bus_result_t data_q;

	// slot frees up in the same cycle the held result transfers
	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= res;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.data  = data_q;

endmodule
`default_nettype wire

// ===== hdl/i2c_eeprom_sequential_reader.sv =====
`default_nettype none
// I2C master for sequential reads from a serial EEPROM.
// in_ch carries tick items {action, page, sda_in}; action=1 while idle starts a
// transaction (start, device write address, word address when page is zero,
// repeated start, device read address, read_length bytes, stop). Every other
// item advances the bus by one tick; a bit phase lasts TICKS_PER_PHASE ticks.
// out_ch carries exactly one result per tick item: pin levels for scl/sda,
// any byte completed on that tick, and busy/done/nack status.
// cfg_wr_en/cfg_index/cfg_data write device_address (0), word_address (1)
// and read_length (2); write only while idle.
// The result is registered and valid in the cycle after the input transfer.
// One item per cycle while the receiver does not stall; the whole phase
// update is one pass through the phase sequencer into the result register.
// Reset: phase goes idle, config registers return to 0x50 / 0x00 / 150,
// output register empties.
// Receiver stall: one result is held; in_ch.ready drops until it transfers,
// so no result is lost and the sequencer does not advance.
module i2c_eeprom_sequential_reader import i2cesr_pkg::*; #(
	parameter int unsigned TICKS_PER_PHASE = TICKS_PER_PHASE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	i2cesr_stream_if.sink              in_ch,
	i2cesr_stream_if.source            out_ch
);
	bus_result_t res;
	logic        can_load;
	logic        step;

	// an item transfers whenever the result slot is free or being drained
	assign in_ch.ready = can_load;
	assign step        = in_ch.valid && can_load;

	i2cesr_core #(
		.TICKS_PER_PHASE(TICKS_PER_PHASE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (step),
		.item     (in_ch.data),
		.res      (res)
	);

	i2cesr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res     (res),
		.can_load(can_load),
		.out_ch  (out_ch)
	);

`ifndef ASSERT_OFF
	// no input transfer while a held result is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.valid && in_ch.ready && out_ch.valid && !out_ch.ready))
		else $error("input transfer with stalled result");
	// every input transfer shows up as a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> out_ch.valid)
		else $error("result missing after input transfer");
	// stop completion only reported while a transaction runs
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.done_res) |-> out_ch.data.busy_res)
		else $error("done without busy");
	// last marker and byte data only with a byte
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data.byte_valid) |->
		(!out_ch.data.last_byte && out_ch.data.read_byte == 8'd0))
		else $error("byte fields set without byte_valid");
`endif

endmodule
`default_nettype wire

// ===== bench/i2cesr_bus_checker.sv =====
`default_nettype none
// Watches both channels of the EEPROM reader, predicts the pin levels and
// status of every tick and compares each result transfer against the oldest
// prediction in order.
module i2cesr_bus_checker import i2cesr_pkg::*; #(
	parameter int unsigned TICKS_PER_PHASE = TICKS_PER_PHASE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire tick_item_t            in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire bus_result_t           out_data,
	output int                         fail_count,
	output int                         pending,
	output logic                       bus_idle,
	output int                         bytes_seen,
	output int                         stops_seen,
	output int                         nacked_stops
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic [6:0] dev_addr;
	logic [7:0] word_addr;
	logic [7:0] rd_len;

	// bus sequencer copy
	phase_t      ph;
	int unsigned tick_cnt;
	logic [2:0]  bit_cnt;
	logic [1:0]  stage;
	logic [7:0]  shreg;
	logic [8:0]  remaining;
	logic [7:0]  page_q;
	logic        nack_q;

	bus_result_t pin_levels_due[$];

	task automatic load_out_byte();
		case (stage)
			STG_DEV_WR: shreg = {dev_addr, 1'b0};
			STG_WORD:   shreg = word_addr;
			default:    shreg = {dev_addr, 1'b1};
		endcase
		bit_cnt = 3'd0;
	endtask

	task automatic advance_bus(input tick_item_t it, output bus_result_t r);
		logic drv;
		logic sdo;
		logic end_ph;
		logic last;
		r = '0;
		r.scl = 1'b1;
		drv = 1'b0;
		sdo = 1'b0;
		if (it.action && ph == PH_IDLE) begin
			page_q = it.page;
			nack_q = 1'b0;
			stage = STG_DEV_WR;
			tick_cnt = 0;
			ph = PH_ST_HIGH;
		end
		if (ph != PH_IDLE) begin
			r.busy_res = 1'b1;
			tick_cnt++;
			end_ph = (tick_cnt >= TICKS_PER_PHASE);
			if (end_ph)
				tick_cnt = 0;
			last = (remaining == 9'd1);
			case (ph)
				PH_ST_HIGH: begin
					drv = 1'b1; sdo = 1'b1;
					if (end_ph) ph = PH_ST_FALL;
				end
				PH_ST_FALL: begin
					drv = 1'b1;
					if (end_ph) begin
						load_out_byte();
						ph = PH_WR_LOW;
					end
				end
				PH_WR_LOW: begin
					r.scl = 1'b0; drv = 1'b1; sdo = shreg[7];
					if (end_ph) ph = PH_WR_HIGH;
				end
				PH_WR_HIGH: begin
					drv = 1'b1; sdo = shreg[7];
					if (end_ph) begin
						shreg = shreg << 1;
						if (bit_cnt < 3'd7) begin
							bit_cnt++;
							ph = PH_WR_LOW;
						end else
							ph = PH_WACK_LOW;
					end
				end
				PH_WACK_LOW: begin
					r.scl = 1'b0;
					if (end_ph) ph = PH_WACK_HIGH;
				end
				PH_WACK_HIGH: begin
					if (end_ph) begin
						if (it.sda_in)
							nack_q = 1'b1;
						if (stage == STG_DEV_WR && page_q == 8'd0) begin
							stage = STG_WORD;
							load_out_byte();
							ph = PH_WR_LOW;
						end else if (stage != STG_DEV_RD) begin
							stage = STG_DEV_RD;
							ph = PH_RS_LOW;
						end else begin
							remaining = (rd_len == 8'd0) ? 9'd256 : {1'b0, rd_len};
							bit_cnt = 3'd0;
							shreg = 8'd0;
							ph = PH_RD_LOW;
						end
					end
				end
				PH_RS_LOW: begin
					r.scl = 1'b0; drv = 1'b1; sdo = 1'b1;
					if (end_ph) ph = PH_ST_HIGH;
				end
				PH_RD_LOW: begin
					r.scl = 1'b0;
					if (end_ph) ph = PH_RD_HIGH;
				end
				PH_RD_HIGH: begin
					if (end_ph) begin
						shreg = {shreg[6:0], it.sda_in};
						if (bit_cnt < 3'd7) begin
							bit_cnt++;
							ph = PH_RD_LOW;
						end else begin
							r.byte_valid = 1'b1;
							r.read_byte = shreg;
							r.last_byte = last;
							ph = PH_MACK_LOW;
						end
					end
				end
				PH_MACK_LOW: begin
					r.scl = 1'b0; drv = 1'b1; sdo = last;
					if (end_ph) ph = PH_MACK_HIGH;
				end
				PH_MACK_HIGH: begin
					drv = 1'b1; sdo = last;
					if (end_ph) begin
						if (last || remaining == 9'd0)
							ph = PH_SP_LOW;
						else begin
							remaining--;
							bit_cnt = 3'd0;
							shreg = 8'd0;
							ph = PH_RD_LOW;
						end
					end
				end
				PH_SP_LOW: begin
					r.scl = 1'b0; drv = 1'b1;
					if (end_ph) ph = PH_SP_HIGH;
				end
				PH_SP_HIGH: begin
					drv = 1'b1;
					if (end_ph) ph = PH_SP_END;
				end
				PH_SP_END: begin
					drv = 1'b1; sdo = 1'b1;
					if (end_ph) begin
						r.done_res = 1'b1;
						ph = PH_IDLE;
					end
				end
				default: ph = PH_IDLE;
			endcase
		end
		r.sda_drive = drv;
		r.sda_out = drv & sdo;
		r.nack_seen = nack_q;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		bus_result_t want;
		if (!arst_n) begin
			dev_addr = DEVICE_ADDRESS_RST;
			word_addr = WORD_ADDRESS_RST;
			rd_len = READ_LENGTH_RST;
			ph = PH_IDLE;
			tick_cnt = 0;
			bit_cnt = 3'd0;
			stage = STG_DEV_WR;
			shreg = 8'd0;
			remaining = 9'd0;
			page_q = 8'd0;
			nack_q = 1'b0;
			pin_levels_due.delete();
			fail_count <= 0;
			pending <= 0;
			bus_idle <= 1'b1;
			bytes_seen <= 0;
			stops_seen <= 0;
			nacked_stops <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
					CFG_WORD_ADDRESS:   word_addr = cfg_data;
					CFG_READ_LENGTH:    rd_len = cfg_data;
					default: ;
				endcase
			end
			// compare first: a result never belongs to an item taken on the same edge
			if (out_valid && out_ready) begin
				if (out_data.byte_valid)
					bytes_seen <= bytes_seen + 1;
				if (out_data.done_res) begin
					stops_seen <= stops_seen + 1;
					if (out_data.nack_seen)
						nacked_stops <= nacked_stops + 1;
				end
				if (pin_levels_due.size() == 0) begin
					$display("%0t: result transfer with nothing expected: %p", $time,
						out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = pin_levels_due.pop_front();
					if (out_data !== want) begin
						$display({"%0t: mismatch expected scl=%b sda_out=%b drv=%b bv=%b ",
							"byte=%02h last=%b busy=%b done=%b nack=%b | actual scl=%b ",
							"sda_out=%b drv=%b bv=%b byte=%02h last=%b busy=%b done=%b ",
							"nack=%b"}, $time,
							want.scl, want.sda_out, want.sda_drive, want.byte_valid,
							want.read_byte, want.last_byte, want.busy_res, want.done_res,
							want.nack_seen,
							out_data.scl, out_data.sda_out, out_data.sda_drive,
							out_data.byte_valid, out_data.read_byte, out_data.last_byte,
							out_data.busy_res, out_data.done_res, out_data.nack_seen);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				advance_bus(in_data, want);
				pin_levels_due.push_back(want);
			end
			pending <= pin_levels_due.size();
			bus_idle <= (ph == PH_IDLE);
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_i2c_eeprom_sequential_reader.sv =====
`default_nettype none
// Top of the EEPROM reader bench. Generates tick items, register settings and
// receiver back-pressure; the checker instance does all prediction and
// comparison and reports its failure count back here for the verdict.
module tb_i2c_eeprom_sequential_reader import i2cesr_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TICKS = TICKS_PER_PHASE_DEF;
	localparam int RANDOM_ITEMS   = 200;
	localparam int LONG_HOLD      = 300;  // receiver hold-off, in cycles
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer on either side

	typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2cesr_stream_if #(.payload_t(tick_item_t))  in_ch ();
	i2cesr_stream_if #(.payload_t(bus_result_t)) out_ch ();

	// checker feedback
	int   chk_fails;
	int   chk_pending;
	logic chk_idle;
	int   chk_bytes;
	int   chk_stops;
	int   chk_nacked;

	// stimulus bookkeeping
	int items_sent    = 0;
	int reads_started = 0;
	int reg_writes    = 0;
	int burst_left    = 0;
	int hold_requests = 0;  // bumped by stimulus, served by the receiver process
	int idle_cycles   = 0;

	i2c_eeprom_sequential_reader #(
		.TICKS_PER_PHASE(TICKS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	i2cesr_bus_checker #(
		.TICKS_PER_PHASE(TICKS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_data     (in_ch.data),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_data    (out_ch.data),
		.fail_count  (chk_fails),
		.pending     (chk_pending),
		.bus_idle    (chk_idle),
		.bytes_seen  (chk_bytes),
		.stops_seen  (chk_stops),
		.nacked_stops(chk_nacked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any transfer on either channel counts as progress. The longest
	// legal quiet stretch is the receiver hold-off, well below the limit.
	initial begin
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
					idle_cycles, chk_pending);
				$display("tb_i2c_eeprom_sequential_reader: FAIL");
				$finish;
			end
		end
	end

	// Receiver pacing: changes only on falling edges. Runs through random
	// modes (always ready, coin flip, mostly ready, periodic, sparse) and
	// serves a long hold-off whenever stimulus asks for one.
	initial begin : rx_pacing
		rx_mode_t mode;
		int mode_left;
		int holds_served;
		int beat;
		mode = RX_OPEN;
		mode_left = 0;
		holds_served = 0;
		beat = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				out_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 4));
					mode_left = $urandom_range(8, 64);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_OPEN:     out_ch.ready = 1'b1;
					RX_COIN:     out_ch.ready = 1'($urandom_range(0, 1));
					RX_MOSTLY:   out_ch.ready = ($urandom_range(0, 9) != 0);
					RX_PERIODIC: out_ch.ready = ((beat % 4) != 3);
					default:     out_ch.ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic pick_sda(input sda_mode_t m);
		case (m)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Offer one tick item, starting at a falling edge, and return at the
	// falling edge after its transfer. valid stays up inside a burst; a gap
	// of random length follows each burst.
	task automatic push_tick(input tick_item_t it);
		int gap;
		in_ch.data = it;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			// occasional long burst gives stretches with no sender idling
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 40);
		end
	endtask

	task automatic idle_tick(input sda_mode_t m);
		tick_item_t it;
		it.action = 1'b0;
		it.page = 8'($urandom);
		it.sda_in = pick_sda(m);
		push_tick(it);
	endtask

	// Stop offering and wait, at falling edges, until every predicted result
	// has had its transfer. The block registers its result and every item
	// makes a result, so the pending count shows when the block is drained.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Single register write, only while the bus is idle and drained.
	task automatic set_one_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		reg_writes++;
	endtask

	// Register writes, only while the bus is idle and drained.
	// Bit 7 of the device address write is junk that the block must mask.
	task automatic set_regs(input logic [6:0] dev, input logic [7:0] word,
			input logic [7:0] len);
		cfg_wr_en = 1'b1;
		cfg_index = CFG_DEVICE_ADDRESS;
		cfg_data = {1'($urandom_range(0, 1)), dev};
		@(negedge clk);
		cfg_index = CFG_WORD_ADDRESS;
		cfg_data = word;
		@(negedge clk);
		cfg_index = CFG_READ_LENGTH;
		cfg_data = len;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		reg_writes += 3;
	endtask

	// One full read: a start request, then ticks until the predicted bus is
	// back to idle. busy_pct of the ticks repeat the start request, which the
	// block must treat as a plain tick. At tick pause_at the sender holds off
	// until every result has come back.
	task automatic run_read(input logic [7:0] page, input sda_mode_t m, input int busy_pct,
			input int pause_at, output int sent);
		tick_item_t it;
		sent = 0;
		it.action = 1'b1;
		it.page = page;
		it.sda_in = pick_sda(m);
		push_tick(it);
		sent++;
		reads_started++;
		while (!chk_idle) begin
			if (sent == pause_at && chk_pending != 0) begin
				in_ch.valid = 1'b0;
				do
					@(negedge clk);
				while (chk_pending != 0);
			end
			it.action = ($urandom_range(0, 99) < busy_pct);
			it.page = 8'($urandom);
			it.sda_in = pick_sda(m);
			push_tick(it);
			sent++;
		end
	endtask

	initial begin : stimulus
		int n;
		int random_sent;
		int pause_at;
		logic [7:0] len;
		logic [7:0] page;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// idle ticks with both extremes of the fields: idle pins, no status
		begin
			tick_item_t it;
			it = '{action: 1'b0, page: 8'hFF, sda_in: 1'b1};
			push_tick(it);
			it = '{action: 1'b0, page: 8'h00, sda_in: 1'b0};
			push_tick(it);
		end
		drain();
		// reset addresses (0x50, word address 0) with a short read length;
		// page zero so the word address goes out. The receiver holds off for a
		// long stretch while the sender keeps offering, so the block stalls
		// its input.
		set_one_reg(CFG_READ_LENGTH, 8'd2);
		hold_requests++;
		run_read(8'h00, SDA_RAND, 0, -1, n);
		drain();

		// top address values, one byte: every ack sampled high (NACK flagged,
		// transfer goes on), byte 0xFF; start requests while busy mixed in
		set_regs(7'h7F, 8'hFF, 8'd1);
		run_read(8'h00, SDA_HIGH, 20, -1, n);
		// all low: acked writes, byte 0x00, nack flag cleared at start;
		// nonzero page skips the word address. Pause mid-read until drained.
		run_read(8'hFF, SDA_LOW, 20, 30, n);
		drain();

		// --- random part ---
		// Mostly complete reads with random content and short lengths, noise
		// from idle ticks and start requests while busy.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 6))
				: 8'($urandom_range(1, 2));
			set_regs(7'($urandom), 8'($urandom), len);
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(0, 3)) begin
					idle_tick(SDA_RAND);
					random_sent++;
				end
				page = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
				pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : -1;
				run_read(page, SDA_RAND, 10, pause_at, n);
				random_sent += n;
			end
			drain();
		end

		// all stimulus taken; wait for every result plus the block's latency
		drain();
		repeat (8) @(negedge clk);

		$display("run covered %0d tick transfers, %0d reads, %0d register writes", items_sent,
			reads_started, reg_writes);
		$display("bus saw %0d bytes read, %0d stops, %0d reads with a NACKed write byte",
			chk_bytes, chk_stops, chk_nacked);
		if (chk_fails == 0 && chk_pending == 0)
			$display("tb_i2c_eeprom_sequential_reader: PASS");
		else
			$display("tb_i2c_eeprom_sequential_reader: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
